// File: rtl/core/lpg_pkg.sv
// package with the shared types and constants of the line pixel generator
`default_nettype none

package lpg_pkg;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_STEP  = 1'b1;
    localparam logic [7:0] ROW_LIMIT  = 8'd191;

    typedef struct packed {
        logic       active;
        logic [7:0] cur_x;
        logic [7:0] cur_y;
        logic [7:0] goal_x;
        logic [7:0] goal_y;
        logic [8:0] twice_dx;
        logic [8:0] twice_dy;
        logic [9:0] balance;
        logic       step_left_x;
        logic       step_up_y;
        logic       x_major;
        logic [7:0] line_color;
    } line_state_t;

    typedef struct packed {
        logic [1:0]  section;
        logic [13:0] offset;
        logic [7:0]  pixel_color;
        logic        last_pixel;
    } pixel_t;

endpackage

`default_nettype wire

// File: rtl/core/lpg_setup.sv
// line setup: direction signs, doubled deltas and initial balance from two endpoints
`default_nettype none

module lpg_setup (
    input  wire logic [7:0]         start_x,
    input  wire logic [7:0]         start_y,
    input  wire logic [7:0]         end_x,
    input  wire logic [7:0]         end_y,
    input  wire logic [7:0]         ink,
    output logic                    rows_ok,
    output lpg_pkg::line_state_t    init_state
);
    import lpg_pkg::*;

    logic       left_x;
    logic       up_y;
    logic [7:0] dx;
    logic [7:0] dy;
    logic       major_x;

    always_comb begin
        rows_ok = (start_y <= ROW_LIMIT) && (end_y <= ROW_LIMIT);
        left_x  = end_x < start_x;
        up_y    = end_y < start_y;
        dx      = left_x ? (start_x - end_x) : (end_x - start_x);
        dy      = up_y ? (start_y - end_y) : (end_y - start_y);
        major_x = dx >= dy;

        init_state.active      = 1'b1;
        init_state.cur_x       = start_x;
        init_state.cur_y       = start_y;
        init_state.goal_x      = end_x;
        init_state.goal_y      = end_y;
        init_state.twice_dx    = {dx, 1'b0};
        init_state.twice_dy    = {dy, 1'b0};
        init_state.step_left_x = left_x;
        init_state.step_up_y   = up_y;
        init_state.x_major     = major_x;
        init_state.line_color  = ink;
        // balance is 2*minor - major, kept modulo 2^10
        if (major_x) begin
            init_state.balance = {1'b0, dy, 1'b0} - {2'b00, dx};
        end else begin
            init_state.balance = {1'b0, dx, 1'b0} - {2'b00, dy};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lpg_step.sv
// one line step: current pixel and the state after it
`default_nettype none

module lpg_step (
    input  wire lpg_pkg::line_state_t cur_state,
    output lpg_pkg::pixel_t           pixel,
    output lpg_pkg::line_state_t      next_state
);
    import lpg_pkg::*;

    logic       last;
    logic       bal_nonneg;
    logic [7:0] x_moved;
    logic [7:0] y_moved;
    logic [9:0] minor_sub;
    logic [9:0] major_add;

    always_comb begin
        last = cur_state.x_major ? (cur_state.cur_x == cur_state.goal_x)
                                 : (cur_state.cur_y == cur_state.goal_y);
        bal_nonneg = !cur_state.balance[9];
        x_moved = cur_state.step_left_x ? (cur_state.cur_x - 8'd1) : (cur_state.cur_x + 8'd1);
        y_moved = cur_state.step_up_y ? (cur_state.cur_y - 8'd1) : (cur_state.cur_y + 8'd1);

        pixel.section     = cur_state.cur_y[7:6];
        pixel.offset      = {cur_state.cur_y[5:0], cur_state.cur_x};
        pixel.pixel_color = cur_state.line_color;
        pixel.last_pixel  = last;

        if (cur_state.x_major) begin
            minor_sub = bal_nonneg ? {1'b0, cur_state.twice_dx} : 10'd0;
            major_add = {1'b0, cur_state.twice_dy};
        end else begin
            minor_sub = bal_nonneg ? {1'b0, cur_state.twice_dy} : 10'd0;
            major_add = {1'b0, cur_state.twice_dx};
        end

        next_state = cur_state;
        if (last) begin
            next_state.active = 1'b0;
        end else begin
            next_state.balance = cur_state.balance - minor_sub + major_add;
            if (cur_state.x_major) begin
                next_state.cur_x = x_moved;
                if (bal_nonneg) begin
                    next_state.cur_y = y_moved;
                end
            end else begin
                next_state.cur_y = y_moved;
                if (bal_nonneg) begin
                    next_state.cur_x = x_moved;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/line_pixel_generator.sv
// line pixel generator: the pixel of an accepted step item is registered and driven on m_tdata
// throughput 1 item per cycle while s_tready is high; each step is computed from the line state register
// start items and steps with no active line produce nothing
// s_tready stays high while the output register is empty or being taken
// synchronous active-low reset clears the line state and the output valid
`default_nettype none

module line_pixel_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // start_x, start_y, end_x, end_y, ink
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // section, offset, pixel_color
    output logic             m_tlast
);
    import lpg_pkg::*;

    line_state_t state_reg;
    line_state_t state_next;
    line_state_t setup_state;
    line_state_t step_state;
    pixel_t      step_pixel;
    pixel_t      pixel_reg;
    pixel_t      pixel_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        rows_ok;
    logic        accept;
    logic        emit;

    lpg_setup u_setup (
        .start_x   (s_tdata[7:0]),
        .start_y   (s_tdata[15:8]),
        .end_x     (s_tdata[23:16]),
        .end_y     (s_tdata[31:24]),
        .ink       (s_tdata[39:32]),
        .rows_ok   (rows_ok),
        .init_state(setup_state)
    );

    lpg_step u_step (
        .cur_state (state_reg),
        .pixel     (step_pixel),
        .next_state(step_state)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign emit     = accept && (s_tuser == KIND_STEP) && state_reg.active;

    always_comb begin
        state_next   = state_reg;
        pixel_next   = pixel_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (accept) begin
            case (s_tuser)
                KIND_START: begin
                    if (rows_ok) begin
                        state_next = setup_state;
                    end else begin
                        state_next.active = 1'b0;
                    end
                end
                KIND_STEP: begin
                    if (state_reg.active) begin
                        state_next   = step_state;
                        pixel_next   = step_pixel;
                        m_valid_next = 1'b1;
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pixel_reg <= pixel_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {pixel_reg.pixel_color, pixel_reg.offset, pixel_reg.section};
    assign m_tlast  = pixel_reg.last_pixel;

    // a step with no line running never produces a pixel
    a_idle_step_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == KIND_STEP && !state_reg.active && m_tready) |=> !m_tvalid)
        else $error("pixel produced without an active line");

    // the endpoint pixel ends the line
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && step_pixel.last_pixel) |=> (!state_reg.active && m_tvalid && m_tlast))
        else $error("line still active after its last pixel");

    // a start with a row off screen leaves no line running
    a_bad_row_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == KIND_START && !rows_ok) |=> !state_reg.active)
        else $error("line active after off-screen start");

    // an emitted pixel always lies on the 192-row screen
    a_section_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("pixel section out of range");

endmodule

`default_nettype wire

// File: test/line_pixel_generator_tb.sv
// testbench for the line pixel generator: directed table, random lines, pixel predictor
`default_nettype none

module line_pixel_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [7:0] ink;
        bit         typed;
        pixel_t     want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = KIND_STEP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    pixel_t pending_pixels[$];
    int     mismatches     = 0;
    int     items_done     = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    bit     hold_request   = 1'b0;

    // predicted line state
    logic              ln_active   = 1'b0;
    logic [7:0]        ln_x        = '0;
    logic [7:0]        ln_y        = '0;
    logic [7:0]        ln_goal_x   = '0;
    logic [7:0]        ln_goal_y   = '0;
    logic [8:0]        ln_twice_dx = '0;
    logic [8:0]        ln_twice_dy = '0;
    logic signed [9:0] ln_balance  = '0;
    logic              ln_left     = 1'b0;
    logic              ln_up       = 1'b0;
    logic              ln_x_major  = 1'b0;
    logic [7:0]        ln_color    = '0;

    line_pixel_generator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic trace_line(input logic kind, input logic [39:0] data,
                              output bit emits, output pixel_t px);
        logic [7:0] x1, y1, x2, y2, dx, dy;
        int b;
        emits = 1'b0;
        px    = '0;
        x1    = data[7:0];
        y1    = data[15:8];
        x2    = data[23:16];
        y2    = data[31:24];
        if (kind == KIND_START) begin
            if (y1 > ROW_LIMIT || y2 > ROW_LIMIT) begin
                ln_active = 1'b0;
            end else begin
                ln_left     = x2 < x1;
                dx          = ln_left ? x1 - x2 : x2 - x1;
                ln_up       = y2 < y1;
                dy          = ln_up ? y1 - y2 : y2 - y1;
                ln_x_major  = dx >= dy;
                ln_twice_dx = {dx, 1'b0};
                ln_twice_dy = {dy, 1'b0};
                b = ln_x_major ? 2 * int'(dy) - int'(dx) : 2 * int'(dx) - int'(dy);
                ln_balance  = b[9:0];
                ln_x        = x1;
                ln_y        = y1;
                ln_goal_x   = x2;
                ln_goal_y   = y2;
                ln_color    = data[39:32];
                ln_active   = 1'b1;
            end
        end else if (ln_active) begin
            emits          = 1'b1;
            px.section     = ln_y[7:6];
            px.offset      = {ln_y[5:0], ln_x};
            px.pixel_color = ln_color;
            px.last_pixel  = ln_x_major ? (ln_x == ln_goal_x) : (ln_y == ln_goal_y);
            if (px.last_pixel) begin
                ln_active = 1'b0;
            end else begin
                b = int'(ln_balance);
                if (ln_x_major) begin
                    if (b >= 0) begin
                        ln_y = ln_up ? ln_y - 8'd1 : ln_y + 8'd1;
                        b -= int'(ln_twice_dx);
                    end
                    b += int'(ln_twice_dy);
                    ln_x = ln_left ? ln_x - 8'd1 : ln_x + 8'd1;
                end else begin
                    if (b >= 0) begin
                        ln_x = ln_left ? ln_x - 8'd1 : ln_x + 8'd1;
                        b -= int'(ln_twice_dy);
                    end
                    b += int'(ln_twice_dx);
                    ln_y = ln_up ? ln_y - 8'd1 : ln_y + 8'd1;
                end
                ln_balance = b[9:0];
            end
        end
    endtask

    // called and returns on a falling edge
    task automatic send_item(input logic kind, input logic [39:0] data,
                             input bit typed, input pixel_t want);
        bit     emits;
        pixel_t px;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        trace_line(kind, data, emits, px);
        if (emits || typed) begin
            pending_pixels.push_back(typed ? want : px);
        end
        if (kind == KIND_START || emits) begin
            items_done++;
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] nearby(input logic [7:0] c, input int top);
        int v;
        v = int'(c) + int'($urandom_range(32)) - 16;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v[7:0];
    endfunction

    // one start followed by the steps that walk its line, sometimes cut short or overrun, sometimes off screen
    task automatic random_line();
        logic [7:0] x1, y1, x2, y2;
        int pick, dx, dy, len, steps;
        pick = $urandom_range(99);
        x1   = 8'($urandom);
        y1   = 8'($urandom_range(191));
        if (pick < 4) begin
            x2 = 8'($urandom);
            y2 = 8'($urandom_range(191));
        end else begin
            x2 = nearby(x1, 255);
            y2 = nearby(y1, 191);
        end
        dx  = x2 > x1 ? int'(x2 - x1) : int'(x1 - x2);
        dy  = y2 > y1 ? int'(y2 - y1) : int'(y1 - y2);
        len = (dx > dy ? dx : dy) + 1;
        case ($urandom_range(9))
            0: steps = $urandom_range(len);
            1: steps = len + $urandom_range(3, 1);
            default: steps = len;
        endcase
        if (pick >= 90) begin
            if (pick[0]) y1 = 8'($urandom_range(255, 192));
            else         y2 = 8'($urandom_range(255, 192));
            steps = $urandom_range(3);
        end
        send_item(KIND_START, {8'($urandom), y2, x2, y1, x1}, 1'b0, '0);
        repeat (steps) send_item(KIND_STEP, {8'($urandom), 32'($urandom)}, 1'b0, '0);
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (64) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : take_pixel
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel data %h last %b", $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[1:0] !== want.section || m_tdata[15:2] !== want.offset ||
                    m_tdata[23:16] !== want.pixel_color || m_tlast !== want.last_pixel) begin
                    $display("%0t: expected section %0d offset %0d color %h last %b",
                             $time, want.section, want.offset, want.pixel_color,
                             want.last_pixel);
                    $display("%0t:   actual section %0d offset %0d color %h last %b",
                             $time, m_tdata[1:0], m_tdata[15:2], m_tdata[23:16], m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        stim_row_t directed_rows [21];
        int        idle_sched [4];
        int        stall_sched [4];
        directed_rows = '{
            // step with no line yet
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            // single-point line in the top-left corner
            '{KIND_START, 8'd0,   8'd0,   8'd0,   8'd0,   8'hFF, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b1,
              '{2'd0, 14'd0, 8'hFF, 1'b1}},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            // single-point line in the bottom-right corner
            '{KIND_START, 8'd255, 8'd191, 8'd255, 8'd191, 8'h00, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b1,
              '{2'd2, 14'd16383, 8'h00, 1'b1}},
            // first row off screen
            '{KIND_START, 8'd10,  8'd192, 8'd20,  8'd20,  8'h11, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            // full diagonal, then replaced by a steep line mid-way
            '{KIND_START, 8'd255, 8'd0,   8'd0,   8'd191, 8'hA5, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b1,
              '{2'd0, 14'd255, 8'hA5, 1'b0}},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            '{KIND_START, 8'd12,  8'd100, 8'd10,  8'd130, 8'h5A, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            // running line dropped by an off-screen start
            '{KIND_START, 8'd0,   8'd0,   8'd3,   8'd3,   8'hC3, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            '{KIND_START, 8'd0,   8'd0,   8'd0,   8'd255, 8'h77, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b0, '0},
            // one row up across the border between the middle and bottom thirds
            '{KIND_START, 8'd0,   8'd128, 8'd0,   8'd127, 8'h3C, 1'b0, '0},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b1,
              '{2'd2, 14'd0, 8'h3C, 1'b0}},
            '{KIND_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   8'h00, 1'b1,
              '{2'd1, 14'd16128, 8'h3C, 1'b1}}
        };
        idle_sched  = '{0, 61, 0, 11};
        stall_sched = '{0, 0, 61, 11};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].kind,
                      {directed_rows[i].ink, directed_rows[i].ey, directed_rows[i].ex,
                       directed_rows[i].sy, directed_rows[i].sx},
                      directed_rows[i].typed, directed_rows[i].want);
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_sched[phase];
            recv_stall_pct = stall_sched[phase];
            // long receiver hold while the sender keeps offering items
            if (phase == 0) hold_request = 1'b1;
            items_done = 0;
            while (items_done < 190) random_line();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
